/* hdl/mh2_pkg.sv */
// Shared constants and types for the streaming 32-bit MurmurHash2 block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package mh2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam int          QUEUE_DEPTH = 2;

    localparam logic [1:0]  PHASE_FULL  = 2'd3;

    // One command from the byte assembler to the hash sequencer.
    typedef struct packed {
        logic        start;
        logic [31:0] start_val;
        logic        mix;
        logic [31:0] word;
        logic        finish;
        logic        tail_valid;
        logic [23:0] tail;
    } t_cmd;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_K1   = 7'b0000010,
        S_K2   = 7'b0000100,
        S_H    = 7'b0001000,
        S_T    = 7'b0010000,
        S_F    = 7'b0100000,
        S_O    = 7'b1000000
    } t_state;

endpackage

/* hdl/mh2_front.sv */
// Byte assembler: packs bytes into little-endian words and issues commands.
// Depends on mh2_pkg.
`timescale 1ns / 1ps

module mh2_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [7:0]       i_data_byte,
    input  logic             i_byte_present,
    input  logic             i_is_first,
    input  logic             i_is_last,
    input  logic [30:0]      i_msg_length,
    input  logic [31:0]      i_seed_value,
    input  logic             i_q_full,
    output logic             o_q_push,
    output mh2_pkg::t_cmd    o_q_cmd
);
    import mh2_pkg::*;

    logic [23:0] r_part, n_part;
    logic [1:0]  r_phase, n_phase;
    logic [23:0] part_eff, part_add;
    logic [1:0]  phase_eff, phase_add;
    logic        accept, word_done;

    assign accept    = i_push && !i_q_full;
    assign part_eff  = i_is_first ? 24'd0 : r_part;
    assign phase_eff = i_is_first ? 2'd0 : r_phase;
    assign word_done = i_byte_present && (phase_eff == PHASE_FULL);

    always_comb begin
        part_add  = part_eff;
        phase_add = phase_eff;
        if (i_byte_present) begin
            if (word_done) begin
                part_add  = 24'd0;
                phase_add = 2'd0;
            end else begin
                phase_add = phase_eff + 2'd1;
                unique case (phase_eff)
                    2'd0:    part_add = {part_eff[23:8], i_data_byte};
                    2'd1:    part_add = {part_eff[23:16], i_data_byte, part_eff[7:0]};
                    2'd2:    part_add = {i_data_byte, part_eff[15:0]};
                    default: part_add = part_eff;
                endcase
            end
        end
        n_part  = i_is_last ? 24'd0 : part_add;
        n_phase = i_is_last ? 2'd0 : phase_add;
    end

    always_comb begin
        o_q_cmd.start      = i_is_first;
        o_q_cmd.start_val  = i_seed_value ^ {1'b0, i_msg_length};
        o_q_cmd.mix        = word_done;
        o_q_cmd.word       = {i_data_byte, part_eff};
        o_q_cmd.finish     = i_is_last;
        o_q_cmd.tail_valid = (phase_add != 2'd0);
        o_q_cmd.tail       = part_add;
    end

    assign o_q_push = accept && (i_is_first || word_done || i_is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part  <= 24'd0;
            r_phase <= 2'd0;
        end else if (accept) begin
            r_part  <= n_part;
            r_phase <= n_phase;
        end
    end

endmodule

/* hdl/mh2_cmdq.sv */
// Small command queue between the byte assembler and the hash sequencer.
// Depends on mh2_pkg for the command type.
`timescale 1ns / 1ps

module mh2_cmdq #(
    parameter int DEPTH = mh2_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mh2_pkg::t_cmd    i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output mh2_pkg::t_cmd    o_cmd,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import mh2_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hdl/mh2_back.sv */
// Hash sequencer: runs start, word mix and finalization on one shared
// constant multiplier and holds the finished hash for the consumer.
// Depends on mh2_pkg.
`timescale 1ns / 1ps

module mh2_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  mh2_pkg::t_cmd    i_q_cmd,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [31:0]      o_hash_value
);
    import mh2_pkg::*;

    t_state      r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [31:0] r_h, n_h;
    logic [31:0] r_k, n_k;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_hash, n_out_hash;
    logic [31:0] mul_in, prod;
    logic        out_free;

    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        unique case (r_state)
            S_K1:    mul_in = r_k;
            S_K2:    mul_in = r_k ^ (r_k >> MIX_SHIFT);
            S_T:     mul_in = r_h ^ {8'd0, r_cmd.tail};
            S_F:     mul_in = r_h ^ (r_h >> FIN_SHIFT_A);
            default: mul_in = r_h;
        endcase
    end

    assign prod = mul_in * MIX_MUL;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_h         = r_h;
        n_k         = r_k;
        n_out_valid = r_out_valid && !i_pop;
        n_out_hash  = r_out_hash;
        o_q_pop     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_k     = i_q_cmd.word;
                    if (i_q_cmd.start) begin
                        n_h = i_q_cmd.start_val;
                    end
                    if (i_q_cmd.mix) begin
                        n_state = S_K1;
                    end else if (i_q_cmd.finish) begin
                        n_state = S_T;
                    end
                end
            end
            S_K1: begin
                n_k     = prod;
                n_state = S_K2;
            end
            S_K2: begin
                n_k     = prod;
                n_state = S_H;
            end
            S_H: begin
                n_h     = prod ^ r_k;
                n_state = r_cmd.finish ? S_T : S_IDLE;
            end
            S_T: begin
                if (r_cmd.tail_valid) begin
                    n_h = prod;
                end
                n_state = S_F;
            end
            S_F: begin
                n_h     = prod;
                n_state = S_O;
            end
            S_O: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hash  = r_h ^ (r_h >> FIN_SHIFT_B);
                    n_h         = 32'd0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_k        <= n_k;
        r_out_hash <= n_out_hash;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_h         <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_h         <= n_h;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_hash_value = r_out_hash;

endmodule

/* hdl/murmur2_hash32_bytes.sv */
// Top level of the streaming 32-bit MurmurHash2 block: byte assembler,
// command queue and hash sequencer. Depends on mh2_pkg and the mh2_* modules.
//
//   Channel  | Handshake        | Payload
//   ---------+------------------+----------------------------------------------
//   input    | i_push / o_full  | i_data_byte, i_byte_present, i_is_first,
//            |                  | i_is_last, i_msg_length, i_seed_value
//   result   | o_empty / i_pop  | o_hash_value
//
// A byte transaction is taken whenever the command queue has room. The
// sequencer pops each command in its idle state and runs a whole word through
// three multiply states (K1, K2, H), so the stream runs at about one byte per
// cycle while results are taken; the single shared 32-bit constant multiplier
// sets that pace. Finishing a message adds the tail, final multiply and result
// load states. Reset is synchronous and active low; the queue, the sequencer
// and the result register come out empty. A full result register stalls only
// the sequencer; the front keeps taking bytes until the queue fills.
`timescale 1ns / 1ps

module murmur2_hash32_bytes #(
    parameter int QUEUE_DEPTH = mh2_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_is_first,
    input  logic        i_is_last,
    input  logic [30:0] i_msg_length,
    input  logic [31:0] i_seed_value,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_hash_value
);
    import mh2_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Commands flow from the front through the queue to the sequencer.
    t_cmd          q_in_cmd, q_out_cmd;
    logic          q_push, q_full, q_pop, q_empty;
    logic [CW-1:0] q_count;

    assign o_full = q_full;

    mh2_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_is_first     (i_is_first),
        .i_is_last      (i_is_last),
        .i_msg_length   (i_msg_length),
        .i_seed_value   (i_seed_value),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_cmd        (q_in_cmd)
    );

    mh2_cmdq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_out_cmd),
        .o_count (q_count)
    );

    mh2_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_cmd      (q_out_cmd),
        .o_q_pop      (q_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_hash_value (o_hash_value)
    );

    // The front must never issue a command into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("command issued into a full queue");

    // The sequencer never pulls from an empty queue.
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty))
        else $error("sequencer popped an empty queue");

    // The queue occupancy stays within its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("command queue occupancy out of range");

    // Right after reset no result is offered.
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> o_empty)
        else $error("result offered right after reset");

endmodule

/* tb/tb_murmur2_hash32_bytes.sv */
// Self-checking testbench for murmur2_hash32_bytes: directed byte messages, then
// random ones, each hash checked against a MurmurHash2 predictor in this file.
// Depends only on the RTL of the block (mh2_pkg and the mh2_* modules).
`timescale 1ns / 1ps

module tb_murmur2_hash32_bytes;

    // The MurmurHash2 multiplier used by the predictor.
    localparam logic [31:0] MURMUR_M       = 32'h5bd1e995;
    localparam int          NUM_DIRECTED   = 25;
    localparam int unsigned TOTAL_ITEMS    = 1450;
    localparam int unsigned HOLD_AT_ITEM   = 200;
    localparam int unsigned PAUSE_AT_ITEM  = 750;
    localparam int unsigned STEADY_AT_ITEM = 1300;
    localparam int          HOLD_CYCLES    = 200;
    localparam int          TAIL_CYCLES    = 20;
    // No accepted transaction on either side for this many cycles means a hang.
    // The longest legal quiet stretch is the long receiver hold-off above.
    localparam int          STALL_LIMIT    = 2000;

    // One input transaction, laid out as the block's input ports.
    typedef struct packed {
        logic [7:0]  data;
        logic        present;
        logic        first;
        logic        last;
        logic [30:0] length;
        logic [31:0] seed;
    } t_byte_txn;

    // One row of the directed table. Where the hash is obvious it is typed in
    // and used as the expectation instead of the predictor's value.
    typedef struct packed {
        logic [7:0]  data;
        logic        present;
        logic        first;
        logic        last;
        logic [30:0] length;
        logic [31:0] seed;
        logic        known;
        logic [31:0] known_hash;
    } t_directed_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_push         = 1'b0;
    logic        o_full;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_is_first     = 1'b0;
    logic        i_is_last      = 1'b0;
    logic [30:0] i_msg_length   = 31'h0;
    logic [31:0] i_seed_value   = 32'h0;
    logic        o_empty;
    logic        i_pop          = 1'b0;
    logic [31:0] o_hash_value;

    // Predictor state: the running hash, the leftover bytes and their count.
    logic [31:0] pred_hash  = 32'h0;
    logic [23:0] pred_tail  = 24'h0;
    logic [1:0]  pred_count = 2'd0;

    logic [31:0]   hash_queue[$];
    int unsigned   mismatch_count = 0;
    int unsigned   items_sent     = 0;
    bit            hold_request   = 1'b0;
    bit            steady_tail    = 1'b0;
    t_directed_row directed_rows [0:NUM_DIRECTED-1];

    murmur2_hash32_bytes u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_is_first     (i_is_first),
        .i_is_last      (i_is_last),
        .i_msg_length   (i_msg_length),
        .i_seed_value   (i_seed_value),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_hash_value   (o_hash_value)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        begin
            $display("%0t ns: mismatch: %s", $time, what);
            mismatch_count++;
        end
    endtask

    // Advances the predictor by one accepted transaction. The steps run in the
    // block's order: start of a message, then the byte, then the finish. A
    // finished hash is returned with done set.
    task automatic murmur_predict(input t_byte_txn t, output bit done,
                                  output logic [31:0] hash);
        logic [31:0] word;
        logic [31:0] h;
        begin
            done = 1'b0;
            hash = 32'h0;
            if (t.first) begin
                pred_hash  = t.seed ^ {1'b0, t.length};
                pred_tail  = 24'h0;
                pred_count = 2'd0;
            end
            if (t.present) begin
                if (pred_count == 2'd3) begin
                    // Fourth byte completes a little-endian word: mix it in.
                    word       = {t.data, pred_tail};
                    word       = word * MURMUR_M;
                    word       = word ^ (word >> 24);
                    word       = word * MURMUR_M;
                    pred_hash  = (pred_hash * MURMUR_M) ^ word;
                    pred_tail  = 24'h0;
                    pred_count = 2'd0;
                end else begin
                    pred_tail[8 * pred_count +: 8] = t.data;
                    pred_count = pred_count + 2'd1;
                end
            end
            if (t.last) begin
                h = pred_hash;
                // Leftover bytes are folded in only when there are any.
                if (pred_count != 2'd0) begin
                    h = h ^ {8'h00, pred_tail};
                    h = h * MURMUR_M;
                end
                h = h ^ (h >> 13);
                h = h * MURMUR_M;
                h = h ^ (h >> 15);
                done       = 1'b1;
                hash       = h;
                pred_hash  = 32'h0;
                pred_tail  = 24'h0;
                pred_count = 2'd0;
            end
        end
    endtask

    // Offers one transaction and returns at the clock edge that accepts it.
    // The push stays high on return, so back-to-back transactions need no
    // second assignment in the same time step; an idle burst lowers it first.
    task automatic offer_byte(input t_byte_txn t, input bit known,
                              input logic [31:0] known_hash);
        int          gap;
        bit          done;
        logic [31:0] hash;
        begin
            if (!steady_tail && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 18);
                i_push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_push         <= 1'b1;
            i_data_byte    <= t.data;
            i_byte_present <= t.present;
            i_is_first     <= t.first;
            i_is_last      <= t.last;
            i_msg_length   <= t.length;
            i_seed_value   <= t.seed;
            do @(posedge i_clk); while (o_full);
            murmur_predict(t, done, hash);
            if (done) hash_queue.push_back(known ? known_hash : hash);
            // A mid-message item with no byte and no marks is simply ignored.
            if (t.present || t.first || t.last) items_sent++;
        end
    endtask

    // Stops offering until every expected hash has been taken. At least one
    // edge passes, so the push is never lowered and raised in one time step.
    task automatic drain_results();
        begin
            i_push <= 1'b0;
            do @(posedge i_clk); while (hash_queue.size() != 0);
        end
    endtask

    // Seed and declared length for an item that opens a message; junk for any
    // other item, since the block does not sample them there.
    function automatic t_byte_txn with_header(input t_byte_txn t, input int remaining);
        t_byte_txn r;
        begin
            r = t;
            if (t.first) begin
                case ($urandom_range(0, 7))
                    0:       r.seed = 32'h0000_0000;
                    1:       r.seed = 32'hffff_ffff;
                    default: r.seed = $urandom;
                endcase
                case ($urandom_range(0, 11))
                    0:       r.length = 31'h7fff_ffff;
                    1:       r.length = 31'($urandom);
                    default: r.length = 31'(remaining);
                endcase
            end else begin
                r.seed   = $urandom;
                r.length = 31'($urandom);
            end
            return r;
        end
    endfunction

    // One random message. Most are well formed with random bytes and mostly
    // short lengths; the rest drop the first mark, restart in the middle
    // (on a byte or on a bare start item), or finish on an item with no byte.
    task automatic send_random_message();
        int        nbytes;
        int        flavor;
        int        restart_at;
        bit        skip_first;
        bit        end_bare;
        t_byte_txn t;
        begin
            nbytes     = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 64)
                                                      : $urandom_range(0, 11);
            flavor     = $urandom_range(0, 9);
            skip_first = (flavor == 0);
            end_bare   = (flavor == 2) || (nbytes == 0);
            restart_at = ((flavor == 1 || flavor == 3) && nbytes > 1)
                         ? $urandom_range(1, nbytes - 1) : -1;
            for (int i = 0; i < nbytes; i++) begin
                if (i > 0 && (i == restart_at && flavor == 3 ||
                              $urandom_range(0, 15) == 0)) begin
                    // Bare item in mid-message: ignored, or a fresh start.
                    t         = t_byte_txn'({$urandom, $urandom, $urandom});
                    t.present = 1'b0;
                    t.first   = (i == restart_at && flavor == 3);
                    t.last    = 1'b0;
                    offer_byte(with_header(t, nbytes - i), 1'b0, 32'h0);
                end
                t.data    = $urandom;
                t.present = 1'b1;
                t.first   = (i == 0 && !skip_first) || (i == restart_at && flavor == 1);
                t.last    = (i == nbytes - 1) && !end_bare;
                offer_byte(with_header(t, nbytes - i), 1'b0, 32'h0);
            end
            if (end_bare) begin
                t.data    = $urandom;
                t.present = 1'b0;
                t.first   = (nbytes == 0) && !skip_first;
                t.last    = 1'b1;
                offer_byte(with_header(t, 0), 1'b0, 32'h0);
            end
        end
    endtask

    // Receiver: checks every accepted hash against the oldest expectation and
    // drives the pop. It rests in random bursts, once in a long hold-off that
    // lets the block fill up and stall its input, and not at all near the end.
    initial begin
        logic [31:0] want;
        int          rest;
        rest = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (i_pop && !o_empty) begin
                if (hash_queue.size() == 0) begin
                    report_mismatch($sformatf("hash %08h with none expected", o_hash_value));
                end else begin
                    want = hash_queue.pop_front();
                    if (o_hash_value !== want)
                        report_mismatch($sformatf("hash_value %08h, expected %08h",
                                                  o_hash_value, want));
                end
            end
            if (rest > 0) begin
                rest--;
                i_pop <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                rest = HOLD_CYCLES - 1;
                i_pop <= 1'b0;
            end else if (!steady_tail && $urandom_range(0, 11) == 0) begin
                rest = $urandom_range(1, 18) - 1;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // Watchdog: counts cycles in which no transaction moves on either side.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (!i_rst_n) @(posedge i_clk);
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_push && !o_full) || (i_pop && !o_empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Sender and end of run.
    initial begin
        t_byte_txn t;
        bit        hold_done;
        bit        paused;
        hold_done = 1'b0;
        paused    = 1'b0;

        // data, present, first, last, length, seed, known, known hash.
        // Items that do not open a message carry junk length and seed.
        directed_rows = '{
            // Empty messages. Seed XOR length of zero hashes to zero.
            '{8'h00, 1'b0, 1'b1, 1'b1, 31'h0000_0000, 32'h0000_0000, 1'b1, 32'h0},
            '{8'h00, 1'b0, 1'b1, 1'b1, 31'h7fff_ffff, 32'h7fff_ffff, 1'b1, 32'h0},
            '{8'hff, 1'b0, 1'b1, 1'b1, 31'h0000_0000, 32'hffff_ffff, 1'b0, 32'h0},
            // One byte, declared length far from the real one.
            '{8'hff, 1'b1, 1'b1, 1'b1, 31'h7fff_ffff, 32'hffff_ffff, 1'b0, 32'h0},
            // One whole word and no leftover bytes at the finish.
            '{8'h00, 1'b1, 1'b1, 1'b0, 31'h0000_0004, 32'h0000_0000, 1'b0, 32'h0},
            '{8'hff, 1'b1, 1'b0, 1'b0, 31'h2aaa_aaaa, 32'h5555_5555, 1'b0, 32'h0},
            '{8'h80, 1'b1, 1'b0, 1'b0, 31'h5555_5555, 32'haaaa_aaaa, 1'b0, 32'h0},
            '{8'h01, 1'b1, 1'b0, 1'b1, 31'h2aaa_aaaa, 32'h5555_5555, 1'b0, 32'h0},
            // Two bytes with an ignored bare item between them.
            '{8'haa, 1'b1, 1'b1, 1'b0, 31'h0000_0002, 32'hdead_beef, 1'b0, 32'h0},
            '{8'h3c, 1'b0, 1'b0, 1'b0, 31'h7fff_ffff, 32'hffff_ffff, 1'b0, 32'h0},
            '{8'h55, 1'b1, 1'b0, 1'b1, 31'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
            // No first mark: continues from the cleared state, three leftovers.
            '{8'h11, 1'b1, 1'b0, 1'b0, 31'h1234_5678, 32'h8765_4321, 1'b0, 32'h0},
            '{8'h22, 1'b1, 1'b0, 1'b0, 31'h1234_5678, 32'h8765_4321, 1'b0, 32'h0},
            '{8'h33, 1'b1, 1'b0, 1'b1, 31'h1234_5678, 32'h8765_4321, 1'b0, 32'h0},
            // A bare start item in mid-message throws away the byte before it.
            '{8'h01, 1'b1, 1'b1, 1'b0, 31'h0000_0003, 32'h0000_0001, 1'b0, 32'h0},
            '{8'h00, 1'b0, 1'b1, 1'b0, 31'h0000_0100, 32'h0000_0002, 1'b0, 32'h0},
            '{8'hc3, 1'b1, 1'b0, 1'b1, 31'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
            // Finish on an item with no byte, two leftovers.
            '{8'h7e, 1'b1, 1'b1, 1'b0, 31'h0000_0002, 32'h0000_0000, 1'b0, 32'h0},
            '{8'h81, 1'b1, 1'b0, 1'b0, 31'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
            '{8'h00, 1'b0, 1'b0, 1'b1, 31'h7fff_ffff, 32'hffff_ffff, 1'b0, 32'h0},
            // Five bytes: one word and a single leftover.
            '{8'hf0, 1'b1, 1'b1, 1'b0, 31'h0000_0005, 32'h8000_0000, 1'b0, 32'h0},
            '{8'h0f, 1'b1, 1'b0, 1'b0, 31'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
            '{8'ha5, 1'b1, 1'b0, 1'b0, 31'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
            '{8'h5a, 1'b1, 1'b0, 1'b0, 31'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
            '{8'hff, 1'b1, 1'b0, 1'b1, 31'h0000_0000, 32'h0000_0000, 1'b0, 32'h0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int row = 0; row < NUM_DIRECTED; row++) begin
            t.data    = directed_rows[row].data;
            t.present = directed_rows[row].present;
            t.first   = directed_rows[row].first;
            t.last    = directed_rows[row].last;
            t.length  = directed_rows[row].length;
            t.seed    = directed_rows[row].seed;
            offer_byte(t, directed_rows[row].known, directed_rows[row].known_hash);
        end
        // The sender waits here until the directed hashes have all come back.
        drain_results();

        while (items_sent < TOTAL_ITEMS) begin
            // Ask the receiver for its long hold-off while bytes keep coming.
            if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!paused && items_sent >= PAUSE_AT_ITEM) begin
                drain_results();
                paused = 1'b1;
            end
            // The last stretch runs with both sides at full rate.
            if (items_sent >= STEADY_AT_ITEM) steady_tail = 1'b1;
            send_random_message();
        end
        i_push <= 1'b0;

        // The watchdog ends the run if expected hashes never arrive.
        do @(posedge i_clk); while (hash_queue.size() != 0);
        // A final wait catches any hash the block should not have produced.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
